>>> rtl/tnsc_pkg.sv
package tnsc_pkg;

   localparam int COORD_BITS     = 12;
   localparam int SLOT_BITS      = 6;
   localparam int GRID_BITS      = 13;
   localparam int COUNT_BITS     = 7;
   localparam int SQ_BITS        = 2 * COORD_BITS;
   localparam int SUM_BITS       = SQ_BITS + 1;
   localparam int DIST_BITS      = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 13;

   localparam logic [GRID_BITS-1:0]  GRID_RESET  = GRID_BITS'(4096);
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);

   localparam logic REQ_WRITE    = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_SEED_COUNT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  req_type;
      logic [SLOT_BITS-1:0]  seed_slot;
      logic [COORD_BITS-1:0] coord_x;
      logic [COORD_BITS-1:0] coord_y;
   } req_item_type;

   typedef struct packed {
      logic                 was_write;
      logic [SLOT_BITS-1:0] nearest_seed;
      logic [DIST_BITS-1:0] distance_sq;
   } rsp_item_type;

   typedef struct packed {
      logic [GRID_BITS-1:0]  grid_width;
      logic [GRID_BITS-1:0]  grid_height;
      logic [COUNT_BITS-1:0] seed_count;
   } cfg_type;

   // One item as it moves along the seed chain, one cell per cycle.
   typedef struct packed {
      logic                  valid;
      logic                  query;
      logic [SLOT_BITS-1:0]  slot;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } point_type;

   // Running best distance; in every cell it trails its point by the axis-distance and square registers.
   typedef struct packed {
      logic                valid;
      logic                query;
      logic [SUM_BITS-1:0] dist_sq;
   } best_type;

endpackage

>>> rtl/tnsc_cell.sv
module tnsc_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  tnsc_pkg::cfg_type   cfg,
   input  tnsc_pkg::point_type pt_in,
   output tnsc_pkg::point_type pt_out,
   input  tnsc_pkg::best_type  best_in,
   input  logic [IDX_W-1:0]    best_idx_in,
   output tnsc_pkg::best_type  best_out,
   output logic [IDX_W-1:0]    best_idx_out
);
   import tnsc_pkg::*;

   localparam bit FIRST = (CELL_INDEX == 0);

   // Wrapped distance along one axis. The result always fits in COORD_BITS.
   function automatic logic [COORD_BITS-1:0] axis_dist(
      input logic [COORD_BITS-1:0] a,
      input logic [COORD_BITS-1:0] b,
      input logic [GRID_BITS-1:0]  size
   );
      logic [COORD_BITS-1:0]        d;
      logic signed [GRID_BITS:0]    w;
      d = (a > b) ? (a - b) : (b - a);
      if (GRID_BITS'(d) > (size >> 1)) begin
         w = $signed({1'b0, size}) - $signed((GRID_BITS + 1)'(d));
      end else begin
         w = $signed((GRID_BITS + 1)'(d));
      end
      if (w < 0) begin
         w = -w;
      end
      return w[COORD_BITS-1:0];
   endfunction

   logic [COORD_BITS-1:0] seed_x_ff, seed_y_ff;
   point_type             pt_ff;

   logic                  v1_ff, q1_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;

   logic                  v2_ff, q2_ff;
   logic [SQ_BITS-1:0]    sqx_ff, sqy_ff;

   logic                  v3_ff, q3_ff;
   logic [SUM_BITS-1:0]   dist_ff, dist_in, sum;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  slot_hit, active, take;

   assign slot_hit = pt_in.valid && (pt_in.query == REQ_WRITE)
                     && (32'(pt_in.slot) == CELL_INDEX);

   always_ff @(posedge clock) begin
      if (slot_hit) begin
         seed_x_ff <= pt_in.x;
         seed_y_ff <= pt_in.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff.valid <= 1'b0;
      end else begin
         pt_ff.valid <= pt_in.valid;
      end
      pt_ff.query <= pt_in.query;
      pt_ff.slot  <= pt_in.slot;
      pt_ff.x     <= pt_in.x;
      pt_ff.y     <= pt_in.y;
   end

   assign pt_out = pt_ff;

   assign dx_in = axis_dist(seed_x_ff, pt_in.x, cfg.grid_width);
   assign dy_in = axis_dist(seed_y_ff, pt_in.y, cfg.grid_height);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= pt_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      q1_ff   <= pt_in.query;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      q2_ff   <= q1_ff;
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      q3_ff   <= q2_ff;
      dist_ff <= dist_in;
      idx_ff  <= idx_in;
   end

   // The first cell always seeds the search; later cells join only when in use.
   assign sum    = SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff);
   assign active = 32'(cfg.seed_count) > CELL_INDEX;
   assign take   = FIRST || (active && (sum < best_in.dist_sq));

   assign dist_in = take ? sum : best_in.dist_sq;
   assign idx_in  = take ? IDX_W'(CELL_INDEX) : best_idx_in;

   assign best_out.valid   = v3_ff;
   assign best_out.query   = q3_ff;
   assign best_out.dist_sq = dist_ff;
   assign best_idx_out     = idx_ff;

endmodule

>>> rtl/toroidal_nearest_seed_classifier_unit.sv
// Nearest-seed classifier on a wrap-around grid.
// An item is taken at a clock edge where start is high and busy is low. A write
// item stores its coordinate in the given seed slot; a classify item returns the
// lowest-indexed seed at the smallest squared wrapped distance.
// Every item produces one result on rsp_item, marked by rsp_strobe for one cycle.
// A new item can be taken in every cycle while busy is low. The item is captured
// at the accepting edge, then moves along the chain of seed cells, one per cycle,
// passes three stages of distance math in the last cell and an output register,
// and then the result strobe rises. Results leave in the order items arrived.
// Each cell holds its own seed, so a write is seen by every later query and by
// no earlier one.
// The csr port sets grid width, grid height and the number of seeds in use; the
// user must write it only while no item is in flight; the block does not enforce this.
// Synchronous reset clears all valid bits and restores the register defaults;
// seed contents are undefined until written. busy is high only during reset.
// The receiver cannot stall, so the pipeline never holds.
module toroidal_nearest_seed_classifier_unit #(
   parameter int MAX_SEEDS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  tnsc_pkg::req_item_type                req_item,
   output logic                                  rsp_strobe,
   output tnsc_pkg::rsp_item_type                rsp_item,
   input  logic                                  csr_we,
   input  logic [tnsc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tnsc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import tnsc_pkg::*;

   localparam int IDX_W = $clog2(MAX_SEEDS);

   cfg_type          cfg_ff;
   point_type        pt_chain [MAX_SEEDS+1];
   best_type         best_chain [MAX_SEEDS+1];
   logic [IDX_W-1:0] idx_chain [MAX_SEEDS+1];
   point_type        pt0_ff;
   logic             rsp_strobe_ff;
   rsp_item_type     rsp_item_ff, rsp_item_in;
   best_type         last;
   logic [IDX_W-1:0] last_idx;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width  <= GRID_RESET;
         cfg_ff.grid_height <= GRID_RESET;
         cfg_ff.seed_count  <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  cfg_ff.grid_width  <= csr_wdata[GRID_BITS-1:0];
            CSR_GRID_HEIGHT: cfg_ff.grid_height <= csr_wdata[GRID_BITS-1:0];
            CSR_SEED_COUNT:  cfg_ff.seed_count  <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt0_ff.valid <= 1'b0;
      end else begin
         pt0_ff.valid <= start && !busy;
      end
      pt0_ff.query <= (req_item.req_type == REQ_CLASSIFY);
      pt0_ff.slot  <= req_item.seed_slot;
      pt0_ff.x     <= req_item.coord_x;
      pt0_ff.y     <= req_item.coord_y;
   end

   assign pt_chain[0]   = pt0_ff;
   assign best_chain[0] = '0;
   assign idx_chain[0]  = '0;

   for (genvar i = 0; i < MAX_SEEDS; i++) begin : g_cell
      tnsc_cell #(
         .CELL_INDEX (i),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cfg          (cfg_ff),
         .pt_in        (pt_chain[i]),
         .pt_out       (pt_chain[i+1]),
         .best_in      (best_chain[i]),
         .best_idx_in  (idx_chain[i]),
         .best_out     (best_chain[i+1]),
         .best_idx_out (idx_chain[i+1])
      );
   end

   assign last     = best_chain[MAX_SEEDS];
   assign last_idx = idx_chain[MAX_SEEDS];

   always_comb begin
      if (last.query) begin
         rsp_item_in.was_write    = 1'b0;
         rsp_item_in.nearest_seed = SLOT_BITS'(last_idx);
         if (|last.dist_sq[SUM_BITS-1:DIST_BITS]) begin
            rsp_item_in.distance_sq = '1;
         end else begin
            rsp_item_in.distance_sq = last.dist_sq[DIST_BITS-1:0];
         end
      end else begin
         rsp_item_in.was_write    = 1'b1;
         rsp_item_in.nearest_seed = '0;
         rsp_item_in.distance_sq  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= last.valid;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

>>> test/tnsc_tb_pkg.sv
package tnsc_tb_pkg;

   import tnsc_pkg::*;

   localparam int SEED_SLOTS = 64;
   localparam logic [DIST_BITS-1:0] DIST_SAT = '1;

   class nearest_seed_scoreboard;
      logic [COORD_BITS-1:0] seed_x [SEED_SLOTS];
      logic [COORD_BITS-1:0] seed_y [SEED_SLOTS];
      bit                    seed_valid [SEED_SLOTS];
      logic [GRID_BITS-1:0]  grid_width;
      logic [GRID_BITS-1:0]  grid_height;
      logic [COUNT_BITS-1:0] seed_count;
      rsp_item_type          expected_labels [$];
      int                    errors;

      function new();
         foreach (seed_valid[i]) begin
            seed_valid[i] = 1'b0;
            seed_x[i] = '0;
            seed_y[i] = '0;
         end
         grid_width = GRID_RESET;
         grid_height = GRID_RESET;
         seed_count = COUNT_RESET;
         errors = 0;
      endfunction

      function void note_config(logic [CSR_INDEX_BITS-1:0] index,
                                logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_GRID_WIDTH: begin
               grid_width = value[GRID_BITS-1:0];
            end
            CSR_GRID_HEIGHT: begin
               grid_height = value[GRID_BITS-1:0];
            end
            CSR_SEED_COUNT: begin
               seed_count = value[COUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // A count of zero still examines slot 0; counts past the table saturate.
      function int seeds_in_use();
         if (seed_count == 0) begin
            return 1;
         end
         if (seed_count > SEED_SLOTS) begin
            return SEED_SLOTS;
         end
         return int'(seed_count);
      endfunction

      // Lowest slot that a classify item would read but that holds no seed yet.
      function int first_empty_slot();
         int n;
         n = seeds_in_use();
         for (int i = 0; i < n; i++) begin
            if (!seed_valid[i]) begin
               return i;
            end
         end
         return -1;
      endfunction

      // Wrapped distance along one axis, squared. A size smaller than the
      // raw distance can make the wrapped value negative; its magnitude is squared.
      function int unsigned wrapped_sq(logic [COORD_BITS-1:0] a,
                                       logic [COORD_BITS-1:0] b,
                                       logic [GRID_BITS-1:0] size);
         int ai;
         int bi;
         int si;
         int d;
         ai = a;
         bi = b;
         si = size;
         d = (ai > bi) ? ai - bi : bi - ai;
         if (d > si / 2) begin
            d = si - d;
         end
         if (d < 0) begin
            d = -d;
         end
         return d * d;
      endfunction

      function void note_request(req_item_type item);
         rsp_item_type label;
         int           n;
         int           best_slot;
         int unsigned  best_dist;
         int unsigned  cand_dist;
         label = '0;
         if (item.req_type == REQ_WRITE) begin
            seed_x[item.seed_slot] = item.coord_x;
            seed_y[item.seed_slot] = item.coord_y;
            seed_valid[item.seed_slot] = 1'b1;
            label.was_write = 1'b1;
         end else begin
            n = seeds_in_use();
            best_slot = 0;
            best_dist = wrapped_sq(seed_x[0], item.coord_x, grid_width) +
                        wrapped_sq(seed_y[0], item.coord_y, grid_height);
            for (int i = 1; i < n; i++) begin
               cand_dist = wrapped_sq(seed_x[i], item.coord_x, grid_width) +
                           wrapped_sq(seed_y[i], item.coord_y, grid_height);
               if (cand_dist < best_dist) begin
                  best_dist = cand_dist;
                  best_slot = i;
               end
            end
            label.was_write = 1'b0;
            label.nearest_seed = best_slot[SLOT_BITS-1:0];
            label.distance_sq = (best_dist > DIST_SAT) ? DIST_SAT
                                                       : best_dist[DIST_BITS-1:0];
         end
         expected_labels = {expected_labels, label};
      endfunction

      function void check_label(rsp_item_type got, time stamp);
         rsp_item_type want;
         if (expected_labels.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                     stamp, got.was_write, got.nearest_seed, got.distance_sq);
            errors++;
            return;
         end
         want = expected_labels.pop_front();
         if (got.was_write !== want.was_write) begin
            $display("%0t: was_write expected %0d actual %0d",
                     stamp, want.was_write, got.was_write);
            errors++;
         end
         if (got.nearest_seed !== want.nearest_seed) begin
            $display("%0t: nearest_seed expected %0d actual %0d",
                     stamp, want.nearest_seed, got.nearest_seed);
            errors++;
         end
         if (got.distance_sq !== want.distance_sq) begin
            $display("%0t: distance_sq expected %0d actual %0d",
                     stamp, want.distance_sq, got.distance_sq);
            errors++;
         end
      endfunction
   endclass

endpackage

>>> test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tnsc_pkg::*;
   import tnsc_tb_pkg::*;

   // Index 3 decodes to no register; writes to it must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = SEED_SLOTS + 16;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   req_item_type              req_item = '0;
   logic                      rsp_strobe;
   rsp_item_type              rsp_item;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   nearest_seed_scoreboard sb;
   int                     sender_idle_pct = 0;

   always #5 clock = ~clock;

   toroidal_nearest_seed_classifier_unit #(
      .MAX_SEEDS(SEED_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_label(rsp_item, $time);
      end
   end

   // Entered and left at a falling edge; start stays high for a following item.
   task automatic send_item(req_item_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sb.note_request(item);
      @(negedge clock);
   endtask

   // Always moves on by at least one falling edge, so start is never
   // lowered and raised again in the same step.
   task automatic wait_idle();
      start <= 1'b0;
      do begin
         @(negedge clock);
      end while (sb.expected_labels.size() != 0);
   endtask

   task automatic set_reg(logic [CSR_INDEX_BITS-1:0] index,
                          logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.note_config(index, value);
      @(negedge clock);
   endtask

   task automatic program_grid(logic [CSR_DATA_BITS-1:0] width,
                               logic [CSR_DATA_BITS-1:0] height,
                               logic [CSR_DATA_BITS-1:0] count);
      set_reg(CSR_GRID_WIDTH, width);
      set_reg(CSR_GRID_HEIGHT, height);
      set_reg(CSR_SEED_COUNT, count);
      csr_we <= 1'b0;
   endtask

   task automatic send_write(int slot, int x, int y);
      req_item_type item;
      item.req_type = REQ_WRITE;
      item.seed_slot = SLOT_BITS'(slot);
      item.coord_x = COORD_BITS'(x);
      item.coord_y = COORD_BITS'(y);
      send_item(item);
   endtask

   task automatic send_query(int x, int y);
      req_item_type item;
      item.req_type = REQ_CLASSIFY;
      item.seed_slot = SLOT_BITS'($urandom);
      item.coord_x = COORD_BITS'(x);
      item.coord_y = COORD_BITS'(y);
      send_item(item);
   endtask

   // Queries go only where every slot in use holds a seed; until then the
   // lowest empty slot is filled instead.
   task automatic send_random_item();
      req_item_type item;
      int           gap;
      int           n;
      int           j;
      item.seed_slot = SLOT_BITS'($urandom);
      item.coord_x = COORD_BITS'($urandom);
      item.coord_y = COORD_BITS'($urandom);
      gap = sb.first_empty_slot();
      n = sb.seeds_in_use();
      if (gap >= 0 || $urandom_range(0, 99) < 30) begin
         item.req_type = REQ_WRITE;
         if (gap >= 0) begin
            item.seed_slot = gap[SLOT_BITS-1:0];
         end
         case ($urandom_range(0, 7))
            0: begin
               // A second seed on top of an existing one can force a tie.
               j = $urandom_range(0, SEED_SLOTS - 1);
               if (sb.seed_valid[j]) begin
                  item.coord_x = sb.seed_x[j];
                  item.coord_y = sb.seed_y[j];
               end
            end
            1: begin
               item.coord_x = $urandom_range(0, 1) ? '1 : '0;
               item.coord_y = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
            end
         endcase
      end else begin
         item.req_type = REQ_CLASSIFY;
         case ($urandom_range(0, 7))
            0, 1, 2: begin
               j = $urandom_range(0, n - 1);
               item.coord_x = sb.seed_x[j] + COORD_BITS'($urandom_range(0, 6)) - 12'd3;
               item.coord_y = sb.seed_y[j] + COORD_BITS'($urandom_range(0, 6)) - 12'd3;
            end
            3: begin
               item.coord_x = $urandom_range(0, 1) ? '1 : '0;
               item.coord_y = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
            end
         endcase
      end
      send_item(item);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_size(int sel);
      case (sel % 6)
         0: return 13'd4096;
         1: return 13'd1;
         2: return CSR_DATA_BITS'($urandom_range(2, 4095));
         3: return 13'd8191;
         4: return 13'd0;
         default: return CSR_DATA_BITS'($urandom_range(1, 4096));
      endcase
   endfunction

   initial begin
      int                       phase;
      logic [CSR_DATA_BITS-1:0] count;
      sb = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, starting from the reset settings.
      send_write(0, 0, 0);
      send_query(0, 0);
      send_query(4095, 4095);
      send_query(2048, 2048);
      send_write(63, 4095, 4095);
      send_write(1, 4095, 0);
      send_write(2, 0, 4095);
      send_write(3, 2048, 2048);
      wait_idle();
      program_grid(13'd4096, 13'd4096, 13'd4);
      send_query(4095, 4095);
      send_query(2047, 2049);
      wait_idle();
      set_reg(CSR_SPARE, '1);
      program_grid(13'd4096, 13'd4096, 13'd0);
      send_query(10, 10);
      wait_idle();
      program_grid(13'd0, 13'd8191, 13'd4);
      send_query(4095, 4095);
      send_query(1, 4094);
      wait_idle();
      program_grid(13'd1, 13'd1, 13'd2);
      send_query(4095, 4095);
      wait_idle();
      program_grid(13'd8191, 13'd8191, 13'd4);
      send_query(4095, 0);
      send_query(0, 0);

      for (int mode = 0; mode < 3; mode++) begin
         sender_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 74 : 0;
         for (int p = 0; p < 4; p++) begin
            phase = mode * 4 + p;
            case (phase % 6)
               0: count = 13'd64;
               1: count = 13'd127;
               2: count = CSR_DATA_BITS'($urandom_range(1, 64));
               3: count = 13'd0;
               4: count = CSR_DATA_BITS'($urandom);
               default: count = CSR_DATA_BITS'($urandom_range(1, 8));
            endcase
            wait_idle();
            program_grid(pick_size(phase + 1), pick_size(phase + 4), count);
            for (int k = 0; k < 70; k++) begin
               if ($urandom_range(0, 149) == 0) begin
                  wait_idle();
               end
               send_random_item();
            end
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.expected_labels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
